// File: rtl/eio_pkg.sv
`timescale 1ns / 1ps

package eio_pkg;

   // CORDIC setup
   localparam int CORDIC_STEPS = 16;
   localparam int ANGLE_BITS   = 16;
   localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   // Field widths
   localparam int HEAD_W = 16;
   localparam int POS_W  = 32;
   localparam int ACC_W  = 48;

   // Internal datapath widths
   localparam int PHASE_W = 32;               // 2^32 is one turn
   localparam int Z_W     = 33;               // residual angle
   localparam int XY_W    = 34;               // 2.30 rotation values, with headroom
   localparam int TRIG_W  = 17;               // Q1.15 with room for +1.0
   localparam int SUM_W   = POS_W + 2;        // sum of two exact deltas
   localparam int PROD_W  = SUM_W + TRIG_W;   // full product
   localparam int INC_W   = PROD_W - 16;      // product after the Q.16 shift

   localparam logic [PHASE_W-1:0] PHASE_MASK  = {PHASE_W{1'b1}} << (PHASE_W - ANGLE_BITS);
   localparam logic [PHASE_W-1:0] EIGHTH_TURN = 32'd536870912;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [TRIG_W-1:0] TRIG_MAX = 17'sd32768;
   localparam logic signed [TRIG_W-1:0] TRIG_MIN = -17'sd32768;

   // Sine and cosine of one heading
   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_v;
      logic signed [TRIG_W-1:0] cos_v;
   } trig_type;

   // Multiply/accumulate controls from the sequencer
   typedef struct packed {
      logic mul_en;    // register a product this cycle
      logic mul_cos;   // 0: sum * sin, 1: sum * cos
      logic acc_x;     // add the held product into X
      logic acc_y;     // add the held product into Y
   } mac_ctl_type;

   // atan(2^-i), 2^32 per turn
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         0:       val = 33'sd536870912;
         1:       val = 33'sd316933406;
         2:       val = 33'sd167458907;
         3:       val = 33'sd85004756;
         4:       val = 33'sd42667331;
         5:       val = 33'sd21354465;
         6:       val = 33'sd10679838;
         7:       val = 33'sd5340245;
         8:       val = 33'sd2670163;
         9:       val = 33'sd1335087;
         10:      val = 33'sd667544;
         11:      val = 33'sd333772;
         12:      val = 33'sd166886;
         13:      val = 33'sd83443;
         14:      val = 33'sd41722;
         15:      val = 33'sd20861;
         16:      val = 33'sd10430;
         17:      val = 33'sd5215;
         18:      val = 33'sd2608;
         19:      val = 33'sd1304;
         20:      val = 33'sd652;
         21:      val = 33'sd326;
         22:      val = 33'sd163;
         23:      val = 33'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/eio_cordic.sv
`timescale 1ns / 1ps

module eio_cordic
   import eio_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [HEAD_W-1:0] heading,
   output logic              done,
   output trig_type          trig
);

   typedef enum logic [2:0] {
      C_IDLE  = 3'b001,
      C_ROT   = 3'b010,
      C_ROUND = 3'b100
   } cstate_type;

   cstate_type              state_ff, state_in;
   logic [STEP_W-1:0]       count_ff, count_in;
   logic signed [XY_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic [1:0]              quad_ff, quad_in;
   logic                    done_ff, done_in;
   trig_type                trig_ff, trig_in;

   logic [PHASE_W-1:0]      phase, rot;
   logic signed [XY_W-1:0]  dx, dy;
   logic signed [Z_W-1:0]   atan_v;
   logic signed [XY_W-1:0]  x_rnd, y_rnd;
   logic signed [TRIG_W-1:0] c_q, s_q;

   // Phase setup: keep the top heading bits, fold into an eighth-turn window
   always_comb begin
      phase = {heading, 16'b0} & PHASE_MASK;
      rot   = phase + EIGHTH_TURN;
   end

   // Shared shift/add step
   always_comb begin
      dx     = y_ff >>> count_ff;
      dy     = x_ff >>> count_ff;
      atan_v = atan_entry(count_ff);
   end

   // Round half up to Q1.15 and clamp
   always_comb begin
      x_rnd = (x_ff + XY_W'(16384)) >>> 15;
      y_rnd = (y_ff + XY_W'(16384)) >>> 15;
      if (x_rnd > XY_W'(TRIG_MAX))      c_q = TRIG_MAX;
      else if (x_rnd < XY_W'(TRIG_MIN)) c_q = TRIG_MIN;
      else                              c_q = x_rnd[TRIG_W-1:0];
      if (y_rnd > XY_W'(TRIG_MAX))      s_q = TRIG_MAX;
      else if (y_rnd < XY_W'(TRIG_MIN)) s_q = TRIG_MIN;
      else                              s_q = y_rnd[TRIG_W-1:0];
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      quad_in  = quad_ff;
      done_in  = 1'b0;
      trig_in  = trig_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               quad_in  = rot[PHASE_W-1 -: 2];
               z_in     = $signed({3'b000, rot[PHASE_W-3:0]}) - $signed({1'b0, EIGHTH_TURN});
               x_in     = CORDIC_GAIN;
               y_in     = '0;
               count_in = '0;
               state_in = C_ROT;
            end
         end
         C_ROT: begin
            if (!z_ff[Z_W-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_v;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_v;
            end
            count_in = count_ff + 1'b1;
            if (count_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            // Quadrant by exact swap and negation
            case (quad_ff)
               2'd0:    begin trig_in.cos_v = c_q;  trig_in.sin_v = s_q;  end
               2'd1:    begin trig_in.cos_v = -s_q; trig_in.sin_v = c_q;  end
               2'd2:    begin trig_in.cos_v = -c_q; trig_in.sin_v = -s_q; end
               default: begin trig_in.cos_v = s_q;  trig_in.sin_v = -c_q; end
            endcase
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      quad_ff  <= quad_in;
      trig_ff  <= trig_in;
   end

   assign done = done_ff;
   assign trig = trig_ff;

endmodule

// File: rtl/eio_mac.sv
`timescale 1ns / 1ps

module eio_mac
   import eio_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mac_ctl_type             ctl,
   input  logic signed [SUM_W-1:0] sum,
   input  trig_type                trig,
   output logic signed [ACC_W-1:0] x_acc,
   output logic signed [ACC_W-1:0] y_acc
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [TRIG_W-1:0] factor;
   logic signed [PROD_W-1:0] rounded;
   logic signed [INC_W-1:0]  inc;
   logic signed [ACC_W-1:0]  acc_sel, acc_sat;
   logic signed [ACC_W:0]    acc_full;

   // Shared multiplier
   always_comb begin
      factor  = ctl.mul_cos ? trig.cos_v : trig.sin_v;
      prod_in = ctl.mul_en ? PROD_W'(sum * factor) : prod_ff;
   end

   // Round to Q.16, add, saturate to 48 bits
   always_comb begin
      rounded  = prod_ff + PROD_W'(32768);
      inc      = rounded[PROD_W-1:16];
      acc_sel  = ctl.acc_y ? y_ff : x_ff;
      acc_full = {acc_sel[ACC_W-1], acc_sel} + (ACC_W + 1)'(inc);
      if (acc_full[ACC_W] != acc_full[ACC_W-1]) begin
         acc_sat = acc_full[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_sat = acc_full[ACC_W-1:0];
      end
      x_in = ctl.acc_x ? acc_sat : x_ff;
      y_in = ctl.acc_y ? acc_sat : y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign x_acc = x_ff;
   assign y_acc = y_ff;

endmodule

// File: rtl/encoder_imu_odometry.sv
`timescale 1ns / 1ps

// Two-wheel dead-reckoning odometry.
// Request channel (req_valid/req_ready): one beat per sensor sample carries the
// heading (65536 per turn) and the left and right wheel positions (Q15.16).
// Response channel (rsp_valid/rsp_ready): one beat per sample with the running
// X and Y positions (Q31.16, saturating at the 48-bit signed range).
// A sample accepted in idle passes through the CORDIC wait, ST_MUL, ST_ACC_X,
// ST_ACC_Y and ST_EMIT before rsp_valid rises, when the output is free.
// A new sample is taken only after the last one has left ST_EMIT; the
// CORDIC unit does one shift/add rotation step per cycle and the multiplier is
// shared between X and Y.
// req_ready is high only while the sequencer is idle.
// Reset clears the stored wheel positions and both accumulators to zero, so the
// first sample's deltas are the full positions. If the receiver stalls, the
// result holds in the output register; the next sample is still accepted and
// worked on, then waits until the previous beat has been taken.
module encoder_imu_odometry
   import eio_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [HEAD_W-1:0]       req_heading_angle,
   input  logic signed [POS_W-1:0] req_left_position,
   input  logic signed [POS_W-1:0] req_right_position,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [ACC_W-1:0] rsp_x_position,
   output logic signed [ACC_W-1:0] rsp_y_position
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CORDIC = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_ACC_X  = 6'b001000,
      ST_ACC_Y  = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic signed [POS_W-1:0] prev_left_ff, prev_left_in;
   logic signed [POS_W-1:0] prev_right_ff, prev_right_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic                    accept;
   logic                    cordic_done;
   trig_type                trig;
   mac_ctl_type             mac_ctl;
   logic signed [ACC_W-1:0] x_acc, y_acc;
   logic signed [POS_W:0]   delta_l, delta_r;

   assign accept = req_valid && req_ready;

   // Exact wheel deltas and their sum
   always_comb begin
      delta_l = {req_left_position[POS_W-1], req_left_position}
              - {prev_left_ff[POS_W-1], prev_left_ff};
      delta_r = {req_right_position[POS_W-1], req_right_position}
              - {prev_right_ff[POS_W-1], prev_right_ff};
   end

   eio_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .heading (req_heading_angle),
      .done    (cordic_done),
      .trig    (trig)
   );

   eio_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .sum   (sum_ff),
      .trig  (trig),
      .x_acc (x_acc),
      .y_acc (y_acc)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      mac_ctl       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sum_in        = SUM_W'(delta_l) + SUM_W'(delta_r);
               prev_left_in  = req_left_position;
               prev_right_in = req_right_position;
               state_in      = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (cordic_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            mac_ctl.mul_en = 1'b1;
            state_in       = ST_ACC_X;
         end
         ST_ACC_X: begin
            // X takes sum*sin while the multiplier forms sum*cos
            mac_ctl.acc_x   = 1'b1;
            mac_ctl.mul_en  = 1'b1;
            mac_ctl.mul_cos = 1'b1;
            state_in        = ST_ACC_Y;
         end
         ST_ACC_Y: begin
            mac_ctl.acc_y = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_acc;
               rsp_y_in     = y_acc;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_x_position = rsp_x_ff;
   assign rsp_y_position = rsp_y_ff;

   // One sample at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while a sample is in flight");

   // CORDIC finishes only while the sequencer waits for it
   a_cordic_in_step: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == ST_CORDIC)
      else $error("CORDIC result outside its wait state");

   // A free output slot takes the result at once
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("result not loaded into a free output register");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import eio_pkg::*;

   // One expected output beat: running X and Y
   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
   } pose_type;

   localparam longint ACC_HI  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ACC_LO  = -ACC_HI - 1;
   localparam longint GAIN_30 = 64'sd652032874;   // CORDIC gain, 2.30
   localparam longint TURN_8  = 64'sd536870912;   // 1/8 turn on the 2^32 phase

   // Headings as fractions of a turn
   localparam logic [HEAD_W-1:0] HEAD_NORTH = 16'd0;
   localparam logic [HEAD_W-1:0] HEAD_EAST  = 16'd16384;
   localparam logic [HEAD_W-1:0] HEAD_SOUTH = 16'd32768;
   localparam logic [HEAD_W-1:0] HEAD_WEST  = 16'd49152;
   localparam logic [HEAD_W-1:0] HEAD_SE    = 16'd24576;   // 3/8 turn
   localparam logic [HEAD_W-1:0] HEAD_NW    = 16'd57344;   // 7/8 turn

   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

   // atan(2^-i), 2^32 per turn
   localparam logic [0:23][31:0] ATAN_LUT = {
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [HEAD_W-1:0]       req_heading_angle;
   logic signed [POS_W-1:0] req_left_position;
   logic signed [POS_W-1:0] req_right_position;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [ACC_W-1:0] rsp_x_position;
   logic signed [ACC_W-1:0] rsp_y_position;

   // Odometry state mirrored by the predictor
   logic signed [POS_W-1:0] wheel_left_q;
   logic signed [POS_W-1:0] wheel_right_q;
   longint                  x_sum;
   longint                  y_sum;

   pose_type pending_poses[$];
   int    pose_errors;
   int    poses_checked;
   int    samples_sent;
   int    send_idle_pct;
   int    stall_pct;
   int    hold_left;

   encoder_imu_odometry uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_heading_angle  (req_heading_angle),
      .req_left_position  (req_left_position),
      .req_right_position (req_right_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_x_position     (rsp_x_position),
      .rsp_y_position     (rsp_y_position)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Round a 2.30 value half up to Q1.15 and clamp to +-1.0
   function automatic longint round_q15(input longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32768) r = 32768;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function automatic longint clamp_acc(input longint v);
      if (v > ACC_HI) return ACC_HI;
      if (v < ACC_LO) return ACC_LO;
      return v;
   endfunction

   // Sine and cosine of a heading: octant reduction, CORDIC, quadrant fix-up
   function automatic void heading_sin_cos(input logic [HEAD_W-1:0] heading,
                                           output longint sn, output longint cs);
      logic [PHASE_W-1:0] phase;
      logic [PHASE_W-1:0] shifted;
      logic [1:0]         quad;
      longint             z, xr, yr, dx, dy, c15, s15;
      phase   = {heading, 16'h0000} & PHASE_MASK;
      shifted = phase + EIGHTH_TURN;
      quad    = shifted[31:30];
      z       = shifted[29:0];
      z       = z - TURN_8;
      xr      = GAIN_30;
      yr      = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = yr >>> i;
         dy = xr >>> i;
         if (z >= 0) begin
            xr = xr - dx;
            yr = yr + dy;
            z  = z - longint'(ATAN_LUT[i]);
         end else begin
            xr = xr + dx;
            yr = yr - dy;
            z  = z + longint'(ATAN_LUT[i]);
         end
      end
      c15 = round_q15(xr);
      s15 = round_q15(yr);
      case (quad)
         2'd0: begin cs = c15;  sn = s15;  end
         2'd1: begin cs = -s15; sn = c15;  end
         2'd2: begin cs = -c15; sn = -s15; end
         default: begin cs = s15; sn = -c15; end
      endcase
   endfunction

   // Dead-reckoning update for one accepted sample; queues the expected pose
   function automatic void advance_pose(input logic [HEAD_W-1:0] heading,
                                        input logic signed [POS_W-1:0] left,
                                        input logic signed [POS_W-1:0] right);
      longint travel, sn, cs;
      pose_type p;
      travel = (longint'(left) - longint'(wheel_left_q))
             + (longint'(right) - longint'(wheel_right_q));
      heading_sin_cos(heading, sn, cs);
      x_sum = clamp_acc(x_sum + ((travel * sn + 32768) >>> 16));
      y_sum = clamp_acc(y_sum + ((travel * cs + 32768) >>> 16));
      wheel_left_q  = left;
      wheel_right_q = right;
      p.x = x_sum[ACC_W-1:0];
      p.y = y_sum[ACC_W-1:0];
      pending_poses.push_back(p);
   endfunction

   // Offer one sample beat and wait for it to be taken
   task automatic send_sample(input logic [HEAD_W-1:0] heading,
                              input logic signed [POS_W-1:0] left,
                              input logic signed [POS_W-1:0] right);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_heading_angle  = heading;
      req_left_position  = left;
      req_right_position = right;
      do @(posedge clock); while (!req_ready);
      advance_pose(heading, left, right);
      samples_sent++;
   endtask

   // Drop valid and wait until every queued pose has come out
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_poses.size() > 0) @(posedge clock);
   endtask

   function automatic logic signed [POS_W-1:0] extreme_pos();
      case ($urandom_range(3))
         0: return POS_MIN;
         1: return POS_MAX;
         2: return '0;
         default: return -1;
      endcase
   endfunction

   // Mostly smooth driving, some arbitrary jumps and rail values
   task automatic random_sample();
      logic [HEAD_W-1:0]       h;
      logic signed [POS_W-1:0] l, r;
      int                      kind;
      kind = $urandom_range(99);
      h = HEAD_W'($urandom);
      if ($urandom_range(9) == 0)
         h = HEAD_W'($urandom_range(7) * 8192 + $urandom_range(2) - 1);
      if (kind < 70) begin
         l = wheel_left_q + ($urandom_range(2097152) - 1048576);
         r = wheel_right_q + ($urandom_range(2097152) - 1048576);
      end else if (kind < 88) begin
         l = $urandom;
         r = $urandom;
      end else begin
         l = extreme_pos();
         r = extreme_pos();
      end
      send_sample(h, l, r);
   endtask

   task automatic flag_field(input string name, input logic signed [ACC_W-1:0] want,
                             input logic signed [ACC_W-1:0] got);
      pose_errors++;
      if (pose_errors <= 10)
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
   endtask

   // Result checker
   always @(posedge clock) begin : check_pose
      pose_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_poses.size() == 0) begin
            pose_errors++;
            if (pose_errors <= 10)
               $display("%0t: pose beat with nothing expected: x=%0d y=%0d",
                        $realtime, rsp_x_position, rsp_y_position);
         end else begin
            want = pending_poses.pop_front();
            poses_checked++;
            if (rsp_x_position !== want.x) flag_field("x_position", want.x, rsp_x_position);
            if (rsp_y_position !== want.y) flag_field("y_position", want.y, rsp_y_position);
         end
      end
   end

   // Receiver: random stalls, or a counted hold when one is requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= stall_pct);
      end
   end

   // Corners: first sample after reset, quadrant and octant edges, rail-to-rail jumps
   task automatic test_directed_cases();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_sample(HEAD_NORTH, POS_MAX, POS_MIN);
      send_sample(HEAD_EAST, 32'sh0001_0000, 32'sh0002_0000);
      send_sample(HEAD_SOUTH, 32'sh0003_0000, 32'sh0003_8000);
      send_sample(HEAD_WEST, 32'sh0004_0000, 32'sh0004_0000);
      send_sample(16'hFFFF, 32'sh0005_0000, 32'sh0005_0001);
      send_sample(16'd8192, 32'sh0006_0000, 32'sh0006_0000);
      send_sample(16'd8191, 32'sh0007_0000, 32'sh0007_0000);
      send_sample(HEAD_SE, 32'sh0008_0000, 32'sh0008_0000);
      send_sample(16'd40960, 32'sh0009_0000, 32'sh0009_0000);
      send_sample(HEAD_NW, 32'sh000A_0000, 32'sh000A_0000);
      send_sample(16'd1, 32'sh000A_0000, 32'sh000A_0000);
      send_sample(HEAD_EAST, POS_MAX, POS_MAX);
      send_sample(HEAD_EAST, POS_MIN, POS_MIN);
      send_sample(HEAD_SOUTH, POS_MAX, POS_MIN);
      send_sample(16'h5555, POS_MIN, POS_MAX);
      send_sample(16'hAAAA, -1, 0);
      wait_drained();
   endtask

   // Random driving under four idling mixes
   task automatic test_random_motion();
      int idle_mix [4] = '{0, 62, 0, 27};
      int stall_mix[4] = '{0, 0, 62, 27};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_mix[ph];
         stall_pct     = stall_mix[ph];
         repeat (160) random_sample();
      end
      wait_drained();
   endtask

   // Long receiver hold while the sender keeps offering, a full drain, then a mixed-stall run and drain
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = 300;
      repeat (20) random_sample();
      wait_drained();
      send_idle_pct = 27;
      stall_pct     = 27;
      repeat (20) random_sample();
      wait_drained();
   endtask

   // Full-swing wheel jumps at 3/8 and 7/8 turn push X up and Y down by
   // billions per beat, then one more jump that way and two back the other way
   task automatic test_full_swing_jumps();
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (12) begin
         send_sample(HEAD_NW, POS_MIN, POS_MIN);
         send_sample(HEAD_SE, POS_MAX, POS_MAX);
      end
      send_sample(HEAD_NW, POS_MIN, POS_MIN);
      send_sample(HEAD_NW, POS_MAX, POS_MAX);
      send_sample(HEAD_SE, POS_MIN, POS_MIN);
      wait_drained();
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_heading_angle  = '0;
      req_left_position  = '0;
      req_right_position = '0;
      rsp_ready          = 1'b0;
      wheel_left_q       = '0;
      wheel_right_q      = '0;
      x_sum              = 0;
      y_sum              = 0;
      pose_errors        = 0;
      poses_checked      = 0;
      samples_sent       = 0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      hold_left          = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_motion();
      test_backpressure();
      test_full_swing_jumps();

      wait_drained();
      repeat (CORDIC_STEPS + 12) @(posedge clock);
      pose_errors += pending_poses.size();

      $display("Run covered %0d samples (%0d poses checked): heading corners, random driving",
               samples_sent, poses_checked);
      $display("under four idling mixes, a long output hold, and full-swing wheel jumps.");
      if (pose_errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatching beats", pose_errors);
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("watchdog expired with %0d poses outstanding", pending_poses.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
